// File: rtl/csw_pkg.sv
// ----------------------------------------------------------------------------
// csw_pkg: shared types and helpers for the set/way sweep generator
// Holds register codes, sweep modes, the emitted-position struct and the
// level search used when a sweep starts or moves to the next level.
// ----------------------------------------------------------------------------
package csw_pkg;

  localparam int MaxLevels = 7;

  // Bit positions inside the cache level ID word
  localparam int IdLouLsb = 27;
  localparam int IdLocLsb = 24;

  // Line bits are the size code plus this bias
  localparam logic [3:0] LineBias = 4'd4;

  // Request kinds
  localparam logic REQ_START   = 1'b0;
  localparam logic REQ_ADVANCE = 1'b1;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_LEVEL_ID = 3'd0,
    CFG_SIZE_L0  = 3'd1,
    CFG_SIZE_L1  = 3'd2,
    CFG_SIZE_L2  = 3'd3,
    CFG_SIZE_L3  = 3'd4,
    CFG_SIZE_L4  = 3'd5,
    CFG_SIZE_L5  = 3'd6,
    CFG_SIZE_L6  = 3'd7
  } cfg_index_t;

  // Sweep modes
  typedef enum logic [1:0] {
    MODE_CLEAN_POU = 2'd0,
    MODE_CLINV_POC = 2'd1,
    MODE_LEVEL0    = 2'd2,
    MODE_RESERVED  = 2'd3
  } mode_t;

  typedef logic [MaxLevels-1:0][27:0] size_arr_t;

  typedef struct packed {
    logic        found;
    logic [2:0]  level;
  } find_t;

  // One emitted operation, before packing
  typedef struct packed {
    logic        op_valid;
    logic        op_kind;
    logic        last;
    logic [2:0]  level;
    logic [9:0]  way;
    logic [14:0] set;
    logic [27:0] size;
  } emit_t;

  // Lowest qualifying level at or above start, below limit
  function automatic find_t find_level(input logic [3:0] from, input logic [1:0] mode,
                                       input logic [2:0] limit, input logic [30:0] id);
    find_t r;
    r = '0;
    for (int l = 0; l < MaxLevels; l++) begin
      if (!r.found && (4'(l) >= from) && (3'(l) < limit) &&
          ((mode == MODE_LEVEL0) || (id[3*l +: 3] > 3'd1))) begin
        r.found = 1'b1;
        r.level = 3'(l);
      end
    end
    return r;
  endfunction

endpackage

// File: rtl/cache_set_way_sweep_generator.sv
// ----------------------------------------------------------------------------
// cache_set_way_sweep_generator: set/way operand generator for cache sweeps
// Turns start/advance requests into packed set/way/level maintenance words.
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  s_*     | in        | s_tvalid/s_tready | request kind, sweep mode
//  m_*     | out       | m_tvalid/m_tready | operand word, kind, valid, last
//  cfg_*   | in        | cfg_valid/ready   | register index, write data
//
//  Each request word gives exactly one result word once the output register
//  can take it: the input register feeds the step logic, which loads the
//  output register when it steps.
//  One word per cycle is sustained while the output is not stalled; the sweep counters update on each step.
//  rst clears the sweep state, the configuration registers and both valid flags.
//  A stalled output holds its word; input keeps flowing while the input
//  register can drain into the output register.
// ----------------------------------------------------------------------------
module cache_set_way_sweep_generator
  import csw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [1:0] sweep_mode, [7:2] zero
  input  logic        s_tuser,   // [0] req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] op_word
  output logic [1:0]  m_tuser,   // [0] op_kind, [1] op_valid
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [30:0] level_id;
  size_arr_t   sizes;
  logic        in_valid;
  logic        in_req;
  logic [1:0]  in_mode;
  logic        advance;
  emit_t       emit;
  logic [31:0] op_word;

  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      level_id <= '0;
      sizes    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LEVEL_ID: level_id  <= cfg_data[30:0];
        CFG_SIZE_L0:  sizes[0]  <= cfg_data[27:0];
        CFG_SIZE_L1:  sizes[1]  <= cfg_data[27:0];
        CFG_SIZE_L2:  sizes[2]  <= cfg_data[27:0];
        CFG_SIZE_L3:  sizes[3]  <= cfg_data[27:0];
        CFG_SIZE_L4:  sizes[4]  <= cfg_data[27:0];
        CFG_SIZE_L5:  sizes[5]  <= cfg_data[27:0];
        CFG_SIZE_L6:  sizes[6]  <= cfg_data[27:0];
        default:      level_id  <= level_id;
      endcase
    end
  end

  // Step when a word is held and the output register can take the result
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // Hold the request word
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_req  <= s_tuser;
      in_mode <= s_tdata[1:0];
    end
  end

  csw_core u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .req      (in_req),
    .mode     (in_mode),
    .level_id (level_id),
    .sizes    (sizes),
    .emit     (emit)
  );

  csw_pack u_pack (
    .emit    (emit),
    .op_word (op_word)
  );

  // Register the result word
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= op_word;
      m_tuser <= {emit.op_valid, emit.op_kind};
      m_tlast <= emit.last;
    end
  end

  // An empty result is always marked last and carries nothing
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[1]) |-> (m_tlast && (m_tdata == 32'd0) && !m_tuser[0]))
    else $error("empty result not last or not zero");

  // Bit 0 of an operand word is never set
  a_bit0_clear: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[0])
    else $error("operand word bit 0 set");

  // With the output register empty, input is always taken
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // Every step loads a result into the output register
  a_step_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("step without result");

endmodule

// File: rtl/csw_pack.sv
// ----------------------------------------------------------------------------
// csw_pack: operand word packer
// Places way at the top bits, set above the line offset and level at bit 1.
// ----------------------------------------------------------------------------
module csw_pack
  import csw_pkg::*;
(
  input  emit_t       emit,
  output logic [31:0] op_word
);

  logic [3:0]  abits;
  logic [3:0]  lbits;
  logic [9:0]  ways_m1;
  logic [31:0] way_part;
  logic [31:0] set_part;
  logic [31:0] lvl_part;

  // Count the bits needed for ways minus one
  always_comb begin
    ways_m1 = emit.size[12:3];
    abits   = 4'd0;
    for (int b = 0; b < 10; b++) begin
      if (ways_m1[b]) abits = 4'(b + 1);
    end
  end

  assign lbits = {1'b0, emit.size[2:0]} + LineBias;

  // Build the three fields
  always_comb begin
    if (abits != 4'd0) begin
      way_part = 32'(emit.way) << (6'd32 - {2'b00, abits});
    end else begin
      way_part = 32'd0;
    end
    set_part = 32'(emit.set) << lbits;
    lvl_part = {28'd0, emit.level, 1'b0};
  end

  assign op_word = emit.op_valid ? (way_part | set_part | lvl_part) : 32'd0;

endmodule

// File: rtl/csw_core.sv
// ----------------------------------------------------------------------------
// csw_core: sweep state and step logic
// Holds the level/way/set counters and computes one emitted operation per step.
// ----------------------------------------------------------------------------
module csw_core
  import csw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic        req,
  input  logic [1:0]  mode,
  input  logic [30:0] level_id,
  input  size_arr_t   sizes,
  output emit_t       emit
);

  logic        active;
  logic [1:0]  active_mode;
  logic [2:0]  cur_level;
  logic [9:0]  cur_way;
  logic [14:0] cur_set;
  logic [2:0]  level_limit;

  logic        active_next;
  logic [1:0]  active_mode_next;
  logic [2:0]  cur_level_next;
  logic [9:0]  cur_way_next;
  logic [14:0] cur_set_next;
  logic [2:0]  level_limit_next;

  logic [2:0]  start_lim;
  find_t       start_find;
  find_t       next_find;
  logic        emit_go;
  logic [1:0]  e_mode;
  logic [2:0]  e_level;
  logic [2:0]  e_limit;
  logic [9:0]  e_way;
  logic [14:0] e_set;
  logic [27:0] e_size;
  logic [15:0] set_inc;
  logic [15:0] set_cnt;
  logic [10:0] way_inc;
  logic [10:0] way_cnt;

  // Level bound for a new sweep
  always_comb begin
    case (mode)
      MODE_CLEAN_POU: start_lim = level_id[IdLouLsb +: 3];
      MODE_CLINV_POC: start_lim = level_id[IdLocLsb +: 3];
      default:        start_lim = 3'd1;
    endcase
  end

  assign start_find = find_level(4'd0, mode, start_lim, level_id);

  // Pick the position to emit
  always_comb begin
    emit_go = 1'b0;
    e_mode  = active_mode;
    e_level = cur_level;
    e_limit = level_limit;
    e_way   = cur_way;
    e_set   = cur_set;
    if (step) begin
      if (req == REQ_START) begin
        if ((mode != MODE_RESERVED) && start_find.found) begin
          emit_go = 1'b1;
          e_mode  = mode;
          e_level = start_find.level;
          e_limit = start_lim;
          e_way   = 10'd0;
          e_set   = 15'd0;
        end
      end else begin
        emit_go = active;
      end
    end
  end

  assign e_size    = (e_level < 3'(MaxLevels)) ? sizes[e_level] : 28'd0;
  assign set_inc   = {1'b0, e_set} + 16'd1;
  assign set_cnt   = {1'b0, e_size[27:13]} + 16'd1;
  assign way_inc   = {1'b0, e_way} + 11'd1;
  assign way_cnt   = {1'b0, e_size[12:3]} + 11'd1;
  assign next_find = find_level({1'b0, e_level} + 4'd1, e_mode, e_limit, level_id);

  // Advance counters and build the emitted operation
  always_comb begin
    active_next      = active;
    active_mode_next = active_mode;
    cur_level_next   = cur_level;
    cur_way_next     = cur_way;
    cur_set_next     = cur_set;
    level_limit_next = level_limit;
    emit             = '0;
    emit.last        = 1'b1;
    if (step && (req == REQ_START)) begin
      active_next = 1'b0;
    end
    if (emit_go) begin
      active_next      = 1'b1;
      active_mode_next = e_mode;
      level_limit_next = e_limit;
      cur_level_next   = e_level;
      emit.op_valid    = 1'b1;
      emit.op_kind     = (e_mode != MODE_CLEAN_POU);
      emit.last        = 1'b0;
      emit.level       = e_level;
      emit.way         = e_way;
      emit.set         = e_set;
      emit.size        = e_size;
      if (set_inc >= set_cnt) begin
        cur_set_next = 15'd0;
        if (way_inc >= way_cnt) begin
          cur_way_next = 10'd0;
          if (next_find.found) begin
            cur_level_next = next_find.level;
          end else begin
            active_next    = 1'b0;
            cur_level_next = 3'd0;
            emit.last      = 1'b1;
          end
        end else begin
          cur_way_next = way_inc[9:0];
        end
      end else begin
        cur_set_next = set_inc[14:0];
        cur_way_next = e_way;
      end
    end
  end

  // Hold sweep state
  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      active_mode <= 2'd0;
      cur_level   <= 3'd0;
      cur_way     <= 10'd0;
      cur_set     <= 15'd0;
      level_limit <= 3'd0;
    end else begin
      active      <= active_next;
      active_mode <= active_mode_next;
      cur_level   <= cur_level_next;
      cur_way     <= cur_way_next;
      cur_set     <= cur_set_next;
      level_limit <= level_limit_next;
    end
  end

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the set/way sweep generator
// Mirrors the sweep counters in a local model, drives start and advance
// requests with random stalls on both streams, rewrites the level ID and
// size registers between phases, and compares every result word in order.
// ----------------------------------------------------------------------------
module tb;
  import csw_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 4;
  localparam int ItemTarget    = 1050;

  // One result word as the block reports it
  typedef struct packed {
    logic [31:0] word;
    logic        kind;
    logic        valid;
    logic        last;
  } sweep_op_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [1:0] sweep_mode, [7:2] zero
  logic        s_tuser;   // [0] req_type
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // [31:0] op_word
  logic [1:0]  m_tuser;   // [0] op_kind, [1] op_valid
  logic        m_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  cache_set_way_sweep_generator i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Local copy of the registers and the sweep counters
  logic [30:0] mdl_level_id;
  logic [27:0] mdl_size [MaxLevels];
  bit          mdl_active;
  logic [1:0]  mdl_mode;
  logic [2:0]  mdl_level;
  logic [9:0]  mdl_way;
  logic [14:0] mdl_set;
  logic [2:0]  mdl_limit;

  sweep_op_t pending_ops [$];

  int  err_count;
  int  items_sent;
  int  words_checked;
  int  sweeps_ended;
  int  cfg_writes;
  int  hold_left;
  bit  src_idle_en;
  bit  sink_stall_en;

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // First level at or above from that the sweep visits, -1 if none
  function automatic int next_swept_level(input int from, input logic [1:0] mode,
                                          input int limit);
    for (int l = from; l < limit && l < MaxLevels; l++) begin
      if (mode == MODE_LEVEL0 || mdl_level_id[3*l +: 3] > 3'd1) return l;
    end
    return -1;
  endfunction

  // Advance the sweep model by one request and return the word it yields
  function automatic sweep_op_t step_sweep(input logic req, input logic [1:0] mode);
    sweep_op_t   r;
    int          lim;
    int          nxt;
    logic [27:0] sz;
    int          lbits;
    int          ways;
    int          sets;
    int          abits;
    int          v;
    int          set_n;
    int          way_n;
    logic [63:0] w;
    r = '{word: 32'd0, kind: 1'b0, valid: 1'b0, last: 1'b1};
    if (req == REQ_START) begin
      mdl_active = 1'b0;
      if (mode == MODE_RESERVED) return r;
      case (mode)
        MODE_CLEAN_POU: lim = int'(mdl_level_id[IdLouLsb +: 3]);
        MODE_CLINV_POC: lim = int'(mdl_level_id[IdLocLsb +: 3]);
        default:        lim = 1;
      endcase
      nxt = next_swept_level(0, mode, lim);
      if (nxt < 0) return r;
      mdl_mode   = mode;
      mdl_limit  = 3'(lim);
      mdl_level  = 3'(nxt);
      mdl_way    = '0;
      mdl_set    = '0;
      mdl_active = 1'b1;
    end else if (!mdl_active) begin
      return r;
    end
    // Pack way, set and level
    sz    = mdl_size[mdl_level];
    lbits = int'(sz[2:0]) + 4;
    ways  = int'(sz[12:3]) + 1;
    sets  = int'(sz[27:13]) + 1;
    abits = 0;
    v     = ways - 1;
    while (v != 0) begin
      abits++;
      v = v >> 1;
    end
    w = '0;
    if (abits != 0) w = 64'(mdl_way) << (32 - abits);
    w = w | (64'(mdl_set) << lbits) | (64'(mdl_level) << 1);
    r.word  = w[31:0];
    r.kind  = (mdl_mode != MODE_CLEAN_POU);
    r.valid = 1'b1;
    r.last  = 1'b0;
    // Step set inside way inside level
    set_n = int'(mdl_set) + 1;
    way_n = int'(mdl_way);
    if (set_n >= sets) begin
      set_n = 0;
      way_n++;
      if (way_n >= ways) begin
        way_n = 0;
        nxt = next_swept_level(int'(mdl_level) + 1, mdl_mode, int'(mdl_limit));
        if (nxt < 0) begin
          mdl_active = 1'b0;
          mdl_level  = '0;
          r.last     = 1'b1;
        end else begin
          mdl_level = 3'(nxt);
        end
      end
    end
    mdl_set = 15'(set_n);
    mdl_way = 10'(way_n);
    return r;
  endfunction

  function automatic logic [27:0] size_word(input int sets_m1, input int ways_m1,
                                            input int line_code);
    return {15'(sets_m1), 10'(ways_m1), 3'(line_code)};
  endfunction

  function automatic logic [31:0] level_id(input int lou, input int loc,
                                           input logic [20:0] types);
    return {2'b00, 3'(lou), 3'(loc), 3'b000, types};
  endfunction

  // Send one request word, with an optional idle burst ahead of it
  task automatic send_req(input logic req, input logic [1:0] mode);
    int gap;
    if (src_idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 8);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {6'b0, mode};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_ops.push_back(step_sweep(req, mode));
    items_sent++;
  endtask

  // Write one register; valid stays up until cfg_release
  task automatic cfg_write(input cfg_index_t idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_LEVEL_ID) mdl_level_id = data[30:0];
    else mdl_size[int'(idx) - int'(CFG_SIZE_L0)] = data[27:0];
    cfg_writes++;
  endtask

  task automatic cfg_release();
    cfg_valid <= 1'b0;
  endtask

  // Drop the source and wait until every expected word has come back
  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (pending_ops.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Requests against the reset configuration
  task automatic test_idle_requests();
    send_req(REQ_ADVANCE, MODE_CLEAN_POU);   // nothing pending
    send_req(REQ_START, MODE_RESERVED);      // unused mode code
    send_req(REQ_START, MODE_CLEAN_POU);     // empty sweep, no levels
    send_req(REQ_START, MODE_CLINV_POC);     // empty sweep, no levels
    send_req(REQ_START, MODE_LEVEL0);        // level 0 whatever its type
    send_req(REQ_ADVANCE, MODE_LEVEL0);
    wait_drain();
  endtask

  // Skip an instruction-only level, then restart in the middle of a sweep
  task automatic test_level_skip();
    cfg_write(CFG_LEVEL_ID, level_id(3, 3, {12'd0, 3'd4, 3'd1, 3'd2}));
    cfg_write(CFG_SIZE_L0, {4'h0, size_word(1, 0, 1)});
    cfg_write(CFG_SIZE_L2, {4'h0, size_word(0, 1, 7)});
    cfg_release();
    send_req(REQ_START, MODE_CLEAN_POU);
    repeat (4) send_req(REQ_ADVANCE, MODE_CLEAN_POU);
    send_req(REQ_START, MODE_CLINV_POC);
    send_req(REQ_ADVANCE, MODE_CLEAN_POU);
    send_req(REQ_START, MODE_LEVEL0);        // drops the running sweep
    send_req(REQ_ADVANCE, MODE_RESERVED);
    wait_drain();
  endtask

  // Largest sizes and levels, then shrink the bounds under a live sweep
  task automatic test_field_extremes();
    cfg_write(CFG_LEVEL_ID, 32'hFFFF_FFFF);
    cfg_write(CFG_SIZE_L0, 32'hFFFF_FFFF);
    cfg_release();
    send_req(REQ_START, MODE_CLINV_POC);
    repeat (3) send_req(REQ_ADVANCE, MODE_CLINV_POC);
    wait_drain();
    cfg_write(CFG_SIZE_L0, 32'd0);
    cfg_release();
    repeat (7) send_req(REQ_ADVANCE, MODE_CLEAN_POU);
    wait_drain();
  endtask

  // Hold the output off long enough that the input stalls
  task automatic test_output_stall();
    src_idle_en = 1'b0;
    cfg_write(CFG_LEVEL_ID, level_id(1, 1, {18'd0, 3'd2}));
    cfg_write(CFG_SIZE_L0, {4'h0, size_word(3, 1, 2)});
    cfg_release();
    hold_left = 100;
    for (int i = 0; i < 40; i++) begin
      if (i % 9 == 0) send_req(REQ_START, MODE_CLINV_POC);
      else send_req(REQ_ADVANCE, MODE_CLINV_POC);
    end
    wait_drain();
    src_idle_en = 1'b1;
  endtask

  // New register values for one phase; most sizes are kept small
  task automatic load_random_config(input bit all_regs);
    logic [31:0] data;
    int          pick;
    for (int i = 0; i < 8; i++) begin
      if (all_regs || $urandom_range(0, 1) == 1) begin
        pick = $urandom_range(0, 15);
        if (i == int'(CFG_LEVEL_ID) || pick == 0) data = $urandom();
        else if (pick == 1) data = {4'($urandom()), size_word(32767, 1023, 7)};
        else data = {4'($urandom()), size_word($urandom_range(0, 5), $urandom_range(0, 3),
                                               $urandom_range(0, 7))};
        cfg_write(cfg_index_t'(i), data);
      end
    end
    cfg_release();
  endtask

  // Mostly complete sweeps, with cut-off sweeps and stray advances mixed in
  task automatic run_random_sweep();
    logic [1:0] mode;
    int         cap;
    int         n;
    mode = ($urandom_range(0, 9) == 0) ? MODE_RESERVED : 2'($urandom_range(0, 2));
    send_req(REQ_START, mode);
    cap = $urandom_range(5, 60);
    n = 0;
    while (mdl_active && n < cap) begin
      send_req(REQ_ADVANCE, 2'($urandom()));
      n++;
    end
    if ($urandom_range(0, 3) == 0) send_req(REQ_ADVANCE, 2'($urandom()));
  endtask

  task automatic test_random_sweeps();
    int phase;
    phase = 0;
    while (items_sent < ItemTarget) begin
      // Quiet streams for the tail of the run
      if (items_sent > ItemTarget - 150) begin
        src_idle_en   = 1'b0;
        sink_stall_en = 1'b0;
      end
      load_random_config(phase == 0);
      repeat ($urandom_range(1, 4)) run_random_sweep();
      wait_drain();
      phase++;
    end
  endtask

  // Output side: random stall bursts plus a counted long hold
  initial begin
    int stall_left;
    stall_left = 0;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if (sink_stall_en && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        stall_left = $urandom_range(1, 8) - 1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Compare each accepted word with the oldest expectation
  always @(posedge clk) begin
    sweep_op_t exp_op;
    sweep_op_t act_op;
    if (!rst && m_tvalid && m_tready) begin
      act_op = '{word: m_tdata, kind: m_tuser[0], valid: m_tuser[1], last: m_tlast};
      if (pending_ops.size() == 0) begin
        $display("%0t unexpected word: expected none, actual %h", $time, act_op);
        err_count++;
      end else begin
        exp_op = pending_ops.pop_front();
        words_checked++;
        if (exp_op.valid && exp_op.last) sweeps_ended++;
        if (act_op.word !== exp_op.word) begin
          $display("%0t op_word: expected %h actual %h", $time, exp_op.word, act_op.word);
          err_count++;
        end
        if (act_op.kind !== exp_op.kind) begin
          $display("%0t op_kind: expected %b actual %b", $time, exp_op.kind, act_op.kind);
          err_count++;
        end
        if (act_op.valid !== exp_op.valid) begin
          $display("%0t op_valid: expected %b actual %b", $time, exp_op.valid, act_op.valid);
          err_count++;
        end
        if (act_op.last !== exp_op.last) begin
          $display("%0t last_op: expected %b actual %b", $time, exp_op.last, act_op.last);
          err_count++;
        end
      end
    end
  end

  // End the run when no word moves for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t watchdog: no word accepted for %0d cycles", $time, WatchdogLimit);
    $display("TB_ERROR");
    $finish;
  end

  // Main sequence
  initial begin
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tuser       = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    err_count     = 0;
    items_sent    = 0;
    words_checked = 0;
    sweeps_ended  = 0;
    cfg_writes    = 0;
    hold_left     = 0;
    src_idle_en   = 1'b1;
    sink_stall_en = 1'b1;
    mdl_level_id  = '0;
    for (int i = 0; i < MaxLevels; i++) mdl_size[i] = '0;
    mdl_active    = 1'b0;
    mdl_mode      = '0;
    mdl_level     = '0;
    mdl_way       = '0;
    mdl_set       = '0;
    mdl_limit     = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_requests();
    test_level_skip();
    test_field_extremes();
    test_output_stall();
    test_random_sweeps();

    wait_drain();
    repeat (10) @(posedge clk);
    if (pending_ops.size() != 0) begin
      $display("%0t %0d expected words never arrived", $time, pending_ops.size());
      err_count++;
    end
    $display("Run covered %0d requests, %0d result words, %0d register writes",
             items_sent, words_checked, cfg_writes);
    $display("Sweeps run to their final word: %0d, mismatches: %0d", sweeps_ended, err_count);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
